>>> rtl/gnss_two_block_frame_parser_macros.svh
// Assertion helpers for the two-block frame parser.
// All of them sample on clk_i and are disabled while rst_ni is low.
`ifndef GNSS_TWO_BLOCK_FRAME_PARSER_MACROS_SVH
`define GNSS_TWO_BLOCK_FRAME_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define GTBFP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define GTBFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define GTBFP_ASSERT_SAME(lbl, ante, cons)

`define GTBFP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/gtbfp_pkg.sv
`default_nettype none

package gtbfp_pkg;

  localparam logic [7:0] FrameStx = 8'h02;
  localparam logic [7:0] FrameEtx = 8'h03;

  localparam logic [7:0] ExpectedTypeReset  = 8'h57;
  localparam logic [7:0] ControlLengthReset = 8'h0A;
  localparam logic [7:0] MaxDataLengthReset = 8'd178;

  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXPECTED_TYPE   = 2'd0,
    CFG_CONTROL_LENGTH  = 2'd1,
    CFG_MAX_DATA_LENGTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_CONSUMED = 3'd0,
    KIND_PASS     = 3'd1,
    KIND_PAYLOAD  = 3'd2,
    KIND_DONE     = 3'd3,
    KIND_REJECT   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    PH_C_STX    = 4'd0,
    PH_C_STATUS = 4'd1,
    PH_C_TYPE   = 4'd2,
    PH_C_LEN    = 4'd3,
    PH_C_DATA   = 4'd4,
    PH_C_SUM    = 4'd5,
    PH_C_ETX    = 4'd6,
    PH_D_STX    = 4'd7,
    PH_D_STATUS = 4'd8,
    PH_D_TYPE   = 4'd9,
    PH_D_LEN    = 4'd10,
    PH_D_DATA   = 4'd11,
    PH_D_SUM    = 4'd12,
    PH_D_ETX    = 4'd13
  } phase_e;

  typedef struct packed {
    logic [7:0] expected_type;
    logic [7:0] control_length;
    logic [7:0] max_data_length;
  } cfg_t;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] running_sum;
    logic [7:0] control_count;
    logic [7:0] data_length;
    logic [7:0] write_index;
  } parse_state_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [7:0] payload_index;
    logic [7:0] payload_length;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/gnss_two_block_frame_parser.sv
`default_nettype none
`include "gnss_two_block_frame_parser_macros.svh"

// Parser for a two-block receiver reply, one byte per request. A reply is a control block
// and then a data block, each framed as STX, status, type, length, payload, checksum, ETX.
// Every accepted byte yields exactly one result in the output register in the next cycle:
// consumed, passed through (idle bytes that are not STX), a data payload byte with its
// index, frame done with the data length, or rejected. The parser takes one byte every
// clock cycle; the only limit is the single output register, which accepts a new byte
// whenever it is empty or is being read in the same cycle. Configuration registers are
// written through the cfg port and take effect on the next byte that uses them.
module gnss_two_block_frame_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gtbfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                    cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    rx_byte_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [2:0]                         kind_o,
  output logic [7:0]                         out_byte_o,
  output logic [7:0]                         payload_index_o,
  output logic [7:0]                         payload_length_o
);

  gtbfp_pkg::cfg_t         cfg_q;
  gtbfp_pkg::parse_state_t state_q;
  gtbfp_pkg::parse_state_t state_d;
  gtbfp_pkg::result_t      step_result;
  gtbfp_pkg::result_t      out_result;
  logic                    space;
  logic                    accept;

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_type   <= gtbfp_pkg::ExpectedTypeReset;
      cfg_q.control_length  <= gtbfp_pkg::ControlLengthReset;
      cfg_q.max_data_length <= gtbfp_pkg::MaxDataLengthReset;
    end else if (cfg_we_i) begin
      unique case (gtbfp_pkg::cfg_idx_e'(cfg_index_i))
        gtbfp_pkg::CFG_EXPECTED_TYPE:   cfg_q.expected_type   <= cfg_data_i;
        gtbfp_pkg::CFG_CONTROL_LENGTH:  cfg_q.control_length  <= cfg_data_i;
        gtbfp_pkg::CFG_MAX_DATA_LENGTH: cfg_q.max_data_length <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: gtbfp_pkg::PH_C_STX, running_sum: 8'd0, control_count: 8'd0,
                   data_length: 8'd0, write_index: 8'd0};
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  gtbfp_step u_step (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .rx_byte_i (rx_byte_i),
    .state_o   (state_d),
    .result_o  (step_result)
  );

  gtbfp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (step_result),
    .out_ready_i (out_ready_i),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign kind_o           = out_result.kind;
  assign out_byte_o       = out_result.out_byte;
  assign payload_index_o  = out_result.payload_index;
  assign payload_length_o = out_result.payload_length;

  `GTBFP_ASSERT_SAME(a_stall_only_when_full, !in_ready_o, out_valid_o)
  `GTBFP_ASSERT_SAME(a_index_only_on_payload,
                     out_valid_o && (kind_o != gtbfp_pkg::KIND_PAYLOAD),
                     payload_index_o == 8'd0)
  `GTBFP_ASSERT_SAME(a_length_only_on_done,
                     out_valid_o && (kind_o != gtbfp_pkg::KIND_DONE),
                     payload_length_o == 8'd0)
  `GTBFP_ASSERT_NEXT(a_idle_byte_passes,
                     accept && (state_q.phase == gtbfp_pkg::PH_C_STX) &&
                     (rx_byte_i != gtbfp_pkg::FrameStx),
                     out_valid_o && (kind_o == gtbfp_pkg::KIND_PASS) &&
                     (out_byte_o == $past(rx_byte_i)))

endmodule

`default_nettype wire

>>> rtl/gtbfp_step.sv
`default_nettype none

module gtbfp_step (
  input  var gtbfp_pkg::parse_state_t state_i,
  input  var gtbfp_pkg::cfg_t         cfg_i,
  input  wire logic [7:0]             rx_byte_i,
  output gtbfp_pkg::parse_state_t     state_o,
  output gtbfp_pkg::result_t          result_o
);

  gtbfp_pkg::phase_e phase_d;
  logic [7:0]        sum_plus;
  logic [7:0]        count_inc;
  logic [7:0]        index_inc;
  logic              type_ok;

  assign sum_plus  = state_i.running_sum + rx_byte_i;
  assign count_inc = state_i.control_count + 8'd1;
  assign index_inc = state_i.write_index + 8'd1;
  assign type_ok   = (rx_byte_i == cfg_i.expected_type);

  // Next phase.
  always_comb begin
    unique case (state_i.phase)
      gtbfp_pkg::PH_C_STX: begin
        phase_d = (rx_byte_i == gtbfp_pkg::FrameStx) ? gtbfp_pkg::PH_C_STATUS
                                                     : gtbfp_pkg::PH_C_STX;
      end
      gtbfp_pkg::PH_C_STATUS: phase_d = gtbfp_pkg::PH_C_TYPE;
      gtbfp_pkg::PH_D_STATUS: phase_d = gtbfp_pkg::PH_D_TYPE;
      gtbfp_pkg::PH_C_TYPE: begin
        phase_d = type_ok ? gtbfp_pkg::PH_C_LEN : gtbfp_pkg::PH_C_STX;
      end
      gtbfp_pkg::PH_D_TYPE: begin
        phase_d = type_ok ? gtbfp_pkg::PH_D_LEN : gtbfp_pkg::PH_C_STX;
      end
      gtbfp_pkg::PH_C_LEN: begin
        if (rx_byte_i != cfg_i.control_length) begin
          phase_d = gtbfp_pkg::PH_C_STX;
        end else if (rx_byte_i == 8'd0) begin
          phase_d = gtbfp_pkg::PH_C_SUM;
        end else begin
          phase_d = gtbfp_pkg::PH_C_DATA;
        end
      end
      gtbfp_pkg::PH_C_DATA: begin
        phase_d = (count_inc == cfg_i.control_length) ? gtbfp_pkg::PH_C_SUM
                                                       : gtbfp_pkg::PH_C_DATA;
      end
      gtbfp_pkg::PH_C_SUM: begin
        phase_d = (rx_byte_i == state_i.running_sum) ? gtbfp_pkg::PH_C_ETX
                                                      : gtbfp_pkg::PH_C_STX;
      end
      gtbfp_pkg::PH_C_ETX: begin
        phase_d = (rx_byte_i == gtbfp_pkg::FrameEtx) ? gtbfp_pkg::PH_D_STX
                                                     : gtbfp_pkg::PH_C_STX;
      end
      gtbfp_pkg::PH_D_STX: begin
        phase_d = (rx_byte_i == gtbfp_pkg::FrameStx) ? gtbfp_pkg::PH_D_STATUS
                                                     : gtbfp_pkg::PH_C_STX;
      end
      gtbfp_pkg::PH_D_LEN: begin
        if (rx_byte_i > cfg_i.max_data_length) begin
          phase_d = gtbfp_pkg::PH_C_STX;
        end else if (rx_byte_i == 8'd0) begin
          phase_d = gtbfp_pkg::PH_D_SUM;
        end else begin
          phase_d = gtbfp_pkg::PH_D_DATA;
        end
      end
      gtbfp_pkg::PH_D_DATA: begin
        phase_d = (index_inc == state_i.data_length) ? gtbfp_pkg::PH_D_SUM
                                                      : gtbfp_pkg::PH_D_DATA;
      end
      gtbfp_pkg::PH_D_SUM: phase_d = gtbfp_pkg::PH_D_ETX;
      gtbfp_pkg::PH_D_ETX: phase_d = gtbfp_pkg::PH_C_STX;
      default:             phase_d = gtbfp_pkg::PH_C_STX;
    endcase
  end

  // Result and datapath updates.
  always_comb begin
    state_o       = state_i;
    state_o.phase = phase_d;
    result_o      = '{kind: gtbfp_pkg::KIND_CONSUMED, out_byte: 8'd0,
                      payload_index: 8'd0, payload_length: 8'd0};
    unique case (state_i.phase)
      gtbfp_pkg::PH_C_STX: begin
        if (rx_byte_i == gtbfp_pkg::FrameStx) begin
          state_o.running_sum   = 8'd0;
          state_o.control_count = 8'd0;
        end else begin
          result_o.kind     = gtbfp_pkg::KIND_PASS;
          result_o.out_byte = rx_byte_i;
        end
      end
      gtbfp_pkg::PH_C_STATUS, gtbfp_pkg::PH_D_STATUS: begin
        state_o.running_sum = sum_plus;
      end
      gtbfp_pkg::PH_C_TYPE, gtbfp_pkg::PH_D_TYPE: begin
        if (type_ok) begin
          state_o.running_sum = sum_plus;
        end else begin
          result_o.kind = gtbfp_pkg::KIND_REJECT;
        end
      end
      gtbfp_pkg::PH_C_LEN: begin
        if (rx_byte_i == cfg_i.control_length) begin
          state_o.running_sum = sum_plus;
        end else begin
          result_o.kind = gtbfp_pkg::KIND_REJECT;
        end
      end
      gtbfp_pkg::PH_C_DATA: begin
        state_o.control_count = count_inc;
        state_o.running_sum   = sum_plus;
      end
      gtbfp_pkg::PH_C_SUM: begin
        if (rx_byte_i != state_i.running_sum) begin
          result_o.kind = gtbfp_pkg::KIND_REJECT;
        end
      end
      gtbfp_pkg::PH_C_ETX: begin
        if (rx_byte_i != gtbfp_pkg::FrameEtx) begin
          result_o.kind = gtbfp_pkg::KIND_REJECT;
        end
      end
      gtbfp_pkg::PH_D_STX: begin
        if (rx_byte_i == gtbfp_pkg::FrameStx) begin
          state_o.running_sum = 8'd0;
        end else begin
          result_o.kind = gtbfp_pkg::KIND_REJECT;
        end
      end
      gtbfp_pkg::PH_D_LEN: begin
        if (rx_byte_i > cfg_i.max_data_length) begin
          result_o.kind       = gtbfp_pkg::KIND_REJECT;
          state_o.running_sum = 8'd0;
        end else begin
          state_o.data_length = rx_byte_i;
          state_o.write_index = 8'd0;
          state_o.running_sum = sum_plus;
        end
      end
      gtbfp_pkg::PH_D_DATA: begin
        result_o.kind          = gtbfp_pkg::KIND_PAYLOAD;
        result_o.out_byte      = rx_byte_i;
        result_o.payload_index = state_i.write_index;
        state_o.write_index    = index_inc;
        state_o.running_sum    = sum_plus;
      end
      gtbfp_pkg::PH_D_SUM: begin
        // The data checksum byte is skipped without a check.
      end
      gtbfp_pkg::PH_D_ETX: begin
        if (rx_byte_i == gtbfp_pkg::FrameEtx) begin
          result_o.kind           = gtbfp_pkg::KIND_DONE;
          result_o.payload_length = state_i.data_length;
        end else begin
          result_o.kind = gtbfp_pkg::KIND_REJECT;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/gtbfp_out_reg.sv
`default_nettype none

module gtbfp_out_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  var gtbfp_pkg::result_t  result_i,
  input  wire logic               out_ready_i,
  output logic                    space_o,
  output logic                    out_valid_o,
  output gtbfp_pkg::result_t      result_o
);

  logic               valid_q;
  logic               valid_d;
  gtbfp_pkg::result_t data_q;

  // A new request may enter when the register is empty or drains this cycle.
  assign space_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

`default_nettype wire
